[rtl/core/qea_pkg.sv]
// qea_pkg: shared types and constants for the quadrature encoder accelerator
// no dependencies; used by quadrature_encoder_accel
`timescale 1ns / 1ps
`default_nettype none

package qea_pkg;

   // encoder slots carried on the result port (fields a, b, c)
   localparam int ENC_SLOTS = 3;
   // encoders actually decoded, 1 to ENC_SLOTS
   localparam int NUM_ENCODERS = 3;

   localparam int PIN_W    = 8;
   localparam int TIME_W   = 16;
   localparam int POS_W    = 16;
   localparam int STEP_W   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   typedef logic [2:0]              pin_idx_type;
   typedef logic [PIN_W-1:0]        pins_type;
   typedef logic [TIME_W-1:0]       time_type;
   typedef logic signed [POS_W-1:0] pos_type;
   typedef logic [STEP_W-1:0]       step_type;
   typedef logic [ENC_SLOTS-1:0]    mask_type;

   // pin pair of each encoder slot
   localparam pin_idx_type UPPER_PIN [ENC_SLOTS] = '{3'd6, 3'd4, 3'd1};
   localparam pin_idx_type LOWER_PIN [ENC_SLOTS] = '{3'd5, 3'd3, 3'd0};

   // register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FAST_THRESHOLD   = 3'd0,
      CSR_MEDIUM_THRESHOLD = 3'd1,
      CSR_FAST_STEP        = 3'd2,
      CSR_MEDIUM_STEP      = 3'd3,
      CSR_SLOW_STEP        = 3'd4
   } csr_idx_type;

   // register reset values
   localparam time_type FAST_THRESHOLD_RST   = 16'd50;
   localparam time_type MEDIUM_THRESHOLD_RST = 16'd100;
   localparam step_type FAST_STEP_RST        = 8'd5;
   localparam step_type MEDIUM_STEP_RST      = 8'd2;
   localparam step_type SLOW_STEP_RST        = 8'd1;

endpackage

`default_nettype wire

[rtl/core/quadrature_encoder_accel.sv]
// quadrature_encoder_accel: three-channel quadrature decoder with
// speed-dependent step size; depends on qea_pkg
`timescale 1ns / 1ps
`default_nettype none

// Each req beat carries one sample of the 8-bit encoder pin port and the
// millisecond time of that sample. The sample is compared with the previous
// one: a change on the upper pin of a pair is one step, up when the two pins
// of the pair differ, down when they match. The time since the last step in
// the same direction picks fast, medium or slow step size (thresholds and
// sizes set through the csr port, to be written only while the block is
// idle, a rule on the user that the block itself does not enforce).
// Each req beat yields exactly one rsp beat with the three wrapping 16-bit
// positions and a mask of the encoders that stepped. Pipeline: an input
// register, then compare/add logic into the result register, so a sample
// enters every cycle unless req_ready is stalled: with rsp_ready low the
// block holds two beats, one in each register, and then stalls req_ready.
// Decoder state (previous pins, step times, positions) updates as a sample
// moves into the result register.
module quadrature_encoder_accel (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // sample input
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [qea_pkg::PIN_W-1:0]           req_pin_sample,
   input  wire logic [qea_pkg::TIME_W-1:0]          req_now_ms,
   // result output
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [qea_pkg::POS_W-1:0]         rsp_position_a,
   output logic signed [qea_pkg::POS_W-1:0]         rsp_position_b,
   output logic signed [qea_pkg::POS_W-1:0]         rsp_position_c,
   output logic [qea_pkg::ENC_SLOTS-1:0]            rsp_moved_mask,
   // configuration writes
   input  wire logic                                csr_we,
   input  wire logic [qea_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [qea_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // configuration registers
   qea_pkg::time_type fast_thr_ff;
   qea_pkg::time_type medium_thr_ff;
   qea_pkg::step_type fast_step_ff;
   qea_pkg::step_type medium_step_ff;
   qea_pkg::step_type slow_step_ff;

   // input stage
   logic               s1_valid_ff;
   qea_pkg::pins_type  s1_pins_ff;
   qea_pkg::time_type  s1_now_ff;

   // decoder state
   qea_pkg::pins_type  last_pins_ff;
   qea_pkg::time_type  up_time_ff   [qea_pkg::ENC_SLOTS];
   qea_pkg::time_type  down_time_ff [qea_pkg::ENC_SLOTS];
   qea_pkg::pos_type   pos_ff       [qea_pkg::ENC_SLOTS];

   qea_pkg::time_type  up_time_in   [qea_pkg::ENC_SLOTS];
   qea_pkg::time_type  down_time_in [qea_pkg::ENC_SLOTS];
   qea_pkg::pos_type   pos_in       [qea_pkg::ENC_SLOTS];
   qea_pkg::mask_type  moved_in;

   // result stage
   logic               rsp_valid_ff;
   qea_pkg::pos_type   rsp_pos_ff   [qea_pkg::ENC_SLOTS];
   qea_pkg::mask_type  rsp_mask_ff;

   logic rsp_free;
   logic s1_advance;

   // result slot opens when empty or being drained this cycle
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && rsp_free;
   assign req_ready  = !s1_valid_ff || rsp_free;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_position_a = rsp_pos_ff[0];
   assign rsp_position_b = rsp_pos_ff[1];
   assign rsp_position_c = rsp_pos_ff[2];
   assign rsp_moved_mask = rsp_mask_ff;

   // per-encoder step decode, all slots in parallel
   always_comb begin
      qea_pkg::pins_type changed;
      qea_pkg::time_type interval;
      qea_pkg::step_type step;
      logic              up;
      changed  = s1_pins_ff ^ last_pins_ff;
      moved_in = '0;
      interval = '0;
      step     = '0;
      up       = 1'b0;
      for (int i = 0; i < qea_pkg::ENC_SLOTS; i++) begin
         up_time_in[i]   = up_time_ff[i];
         down_time_in[i] = down_time_ff[i];
         pos_in[i]       = pos_ff[i];
         if (i < qea_pkg::NUM_ENCODERS && changed[qea_pkg::UPPER_PIN[i]]) begin
            up = s1_pins_ff[qea_pkg::UPPER_PIN[i]] ^ s1_pins_ff[qea_pkg::LOWER_PIN[i]];
            // interval since last step in this direction, wraps at 16 bits
            if (up) begin
               interval      = s1_now_ff - up_time_ff[i];
               up_time_in[i] = s1_now_ff;
            end else begin
               interval        = s1_now_ff - down_time_ff[i];
               down_time_in[i] = s1_now_ff;
            end
            if (interval < fast_thr_ff) begin
               step = fast_step_ff;
            end else if (interval < medium_thr_ff) begin
               step = medium_step_ff;
            end else begin
               step = slow_step_ff;
            end
            if (up) begin
               pos_in[i] = pos_ff[i] + qea_pkg::pos_type'({8'd0, step});
            end else begin
               pos_in[i] = pos_ff[i] - qea_pkg::pos_type'({8'd0, step});
            end
            moved_in[i] = 1'b1;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fast_thr_ff    <= qea_pkg::FAST_THRESHOLD_RST;
         medium_thr_ff  <= qea_pkg::MEDIUM_THRESHOLD_RST;
         fast_step_ff   <= qea_pkg::FAST_STEP_RST;
         medium_step_ff <= qea_pkg::MEDIUM_STEP_RST;
         slow_step_ff   <= qea_pkg::SLOW_STEP_RST;
      end else if (csr_we) begin
         unique case (qea_pkg::csr_idx_type'(csr_index))
            qea_pkg::CSR_FAST_THRESHOLD:   fast_thr_ff    <= csr_wdata;
            qea_pkg::CSR_MEDIUM_THRESHOLD: medium_thr_ff  <= csr_wdata;
            qea_pkg::CSR_FAST_STEP:        fast_step_ff   <= csr_wdata[qea_pkg::STEP_W-1:0];
            qea_pkg::CSR_MEDIUM_STEP:      medium_step_ff <= csr_wdata[qea_pkg::STEP_W-1:0];
            qea_pkg::CSR_SLOW_STEP:        slow_step_ff   <= csr_wdata[qea_pkg::STEP_W-1:0];
            default: ;  // unknown index, write dropped
         endcase
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_pins_ff <= req_pin_sample;
         s1_now_ff  <= req_now_ms;
      end
   end

   // decoder state, updated as a sample moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         last_pins_ff <= '0;
         for (int i = 0; i < qea_pkg::ENC_SLOTS; i++) begin
            up_time_ff[i]   <= '0;
            down_time_ff[i] <= '0;
            pos_ff[i]       <= '0;
         end
      end else if (s1_advance) begin
         last_pins_ff <= s1_pins_ff;
         for (int i = 0; i < qea_pkg::ENC_SLOTS; i++) begin
            up_time_ff[i]   <= up_time_in[i];
            down_time_ff[i] <= down_time_in[i];
            pos_ff[i]       <= pos_in[i];
         end
      end
   end

   // result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         for (int i = 0; i < qea_pkg::ENC_SLOTS; i++) begin
            rsp_pos_ff[i] <= pos_in[i];
         end
         rsp_mask_ff <= moved_in;
      end
   end

endmodule

`default_nettype wire
